// File: rtl/lst_pkg.sv
// ----------------------------------------------------------------------------
// LCD scanline timing package
// Shared constants, register indexes and record types for the scanline
// timing generator.
// ----------------------------------------------------------------------------
package lst_pkg;

  // Field widths
  localparam int unsigned AdvW   = 11;
  localparam int unsigned CountW = 12;
  localparam int unsigned SumW   = CountW + 1;
  localparam int unsigned LineW  = 8;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned CfgAddrW = 2;

  // Stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Horizontal timing, in cycles within a line
  localparam logic [SumW-1:0] DrawCycles      = SumW'(960);
  localparam logic [SumW-1:0] LineCycles      = SumW'(1232);
  localparam logic [SumW-1:0] HblankFlagCycle = SumW'(1006);
  localparam logic [SumW-1:0] CountMax        = SumW'(4095);

  // Vertical timing, in lines
  localparam logic [LineW-1:0] VisibleLines  = LineW'(160);
  localparam logic [LineW-1:0] VblankEndLine = LineW'(227);
  localparam logic [LineW-1:0] TotalLines    = LineW'(228);
  localparam logic [LineW-1:0] CaptureFirst  = LineW'(2);
  localparam logic [LineW-1:0] CaptureEnd    = LineW'(162);

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegHblankIrqEn = 2'd0;
  localparam logic [CfgAddrW-1:0] RegVblankIrqEn = 2'd1;
  localparam logic [CfgAddrW-1:0] RegMatchIrqEn  = 2'd2;
  localparam logic [CfgAddrW-1:0] RegLineCompare = 2'd3;

  // Configuration register contents
  typedef struct packed {
    logic             hblank_irq_enable;
    logic             vblank_irq_enable;
    logic             line_match_irq_enable;
    logic [LineW-1:0] line_compare;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic             line_match;
    logic             in_vblank;
    logic             in_hblank;
    logic [LineW-1:0] line_number;
    logic             frame_swap;
    logic             render_line_req;
    logic             capture_dma_trig;
    logic             vblank_dma_trig;
    logic             hblank_dma_trig;
    logic             match_irq_req;
    logic             vblank_irq_req;
    logic             hblank_irq_req;
  } result_t;

endpackage

// File: rtl/lcd_scanline_timing.sv
// Flow: an accepted item waits in the input register; when the result register is free or
// being drained, its result is taken into the result register and shown on the master side.
// Throughput: one item per cycle while the result register is free or being drained; the
// timing state updates as each item is processed, so a new item is accepted while the last one steps.
// Reset (rst_ni, asynchronous, active low) clears the cycle counter, line
// counter, status flags, configuration registers and both stage valids.
// ----------------------------------------------------------------------------
// LCD scanline timing generator
// Stream wrapper: input register, timing step and result register.
// ----------------------------------------------------------------------------
module lcd_scanline_timing (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [lst_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [lst_pkg::CfgW-1:0]       cfg_wdata_i,
  // Input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [10:0] cycle_advance, [15:11] zero
  input  logic [lst_pkg::InDataW-1:0]    s_axis_tdata,
  // Result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] hblank_irq_req, [1] vblank_irq_req, [2] match_irq_req,
  // [3] hblank_dma_trig, [4] vblank_dma_trig, [5] capture_dma_trig,
  // [6] render_line_req, [7] frame_swap, [15:8] line_number,
  // [16] in_hblank, [17] in_vblank, [18] line_match, [23:19] zero
  output logic [lst_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned ResW = $bits(lst_pkg::result_t);

  lst_pkg::cfg_t              cfg;
  lst_pkg::result_t           result;
  logic                       in_valid_q;
  logic [lst_pkg::AdvW-1:0]   adv_q;
  logic                       out_valid_q;
  lst_pkg::result_t           out_q;
  logic                       step;

  lst_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // An item is processed when the result register is free or being drained.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  lst_step u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .cycle_advance_i (adv_q),
    .cfg_i           (cfg),
    .result_o        (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      adv_q <= s_axis_tdata[lst_pkg::AdvW-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(lst_pkg::OutDataW - ResW)'(0), out_q};

endmodule

// File: rtl/lst_cfg.sv
// ----------------------------------------------------------------------------
// LCD scanline timing configuration registers
// Holds the interrupt enables and the line compare value.
// ----------------------------------------------------------------------------
module lst_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lst_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [lst_pkg::CfgW-1:0]      cfg_wdata_i,
  output lst_pkg::cfg_t                 cfg_o
);

  lst_pkg::cfg_t cfg_q, cfg_d;

  // Write decode; bits above a register's width are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lst_pkg::RegHblankIrqEn: cfg_d.hblank_irq_enable     = cfg_wdata_i[0];
        lst_pkg::RegVblankIrqEn: cfg_d.vblank_irq_enable     = cfg_wdata_i[0];
        lst_pkg::RegMatchIrqEn:  cfg_d.line_match_irq_enable = cfg_wdata_i[0];
        lst_pkg::RegLineCompare: cfg_d.line_compare          = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/lst_step.sv
// ----------------------------------------------------------------------------
// LCD scanline timing step
// Timing state and the per-item update: advances the line cycle counter and
// handles at most one boundary per item.
// ----------------------------------------------------------------------------
module lst_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [lst_pkg::AdvW-1:0]    cycle_advance_i,
  input  lst_pkg::cfg_t               cfg_i,
  output lst_pkg::result_t            result_o
);

  logic [lst_pkg::CountW-1:0] count_q, count_d;
  logic [lst_pkg::LineW-1:0]  line_q, line_d;
  logic                       hblank_q, hblank_d;
  logic                       vblank_q, vblank_d;
  logic                       match_q, match_d;

  logic [lst_pkg::SumW-1:0]   sum;
  logic [lst_pkg::SumW-1:0]   next_sum;
  logic [lst_pkg::LineW-1:0]  line_inc;
  logic                       draw_hit, line_hit, hflag_hit;

  assign sum = {1'b0, count_q} + lst_pkg::SumW'(cycle_advance_i);

  // Boundary detection in priority order: draw end, line end, hblank flag.
  assign draw_hit  = ({1'b0, count_q} < lst_pkg::DrawCycles) &&
                     (sum >= lst_pkg::DrawCycles);
  assign line_hit  = !draw_hit && (sum >= lst_pkg::LineCycles);
  assign hflag_hit = !draw_hit && !line_hit &&
                     ({1'b0, count_q} < lst_pkg::HblankFlagCycle) &&
                     (sum >= lst_pkg::HblankFlagCycle);

  assign line_inc = line_q + lst_pkg::LineW'(1);

  // Next state and result pulses.
  always_comb begin
    line_d   = line_q;
    hblank_d = hblank_q;
    vblank_d = vblank_q;
    match_d  = match_q;
    next_sum = sum;
    result_o = '0;

    if (draw_hit) begin
      result_o.hblank_irq_req = cfg_i.hblank_irq_enable;
      if (line_q < lst_pkg::VisibleLines) begin
        result_o.render_line_req = 1'b1;
        result_o.hblank_dma_trig = 1'b1;
      end
      result_o.capture_dma_trig = (line_q >= lst_pkg::CaptureFirst) &&
                                  (line_q < lst_pkg::CaptureEnd);
    end else if (line_hit) begin
      next_sum = sum - lst_pkg::LineCycles;
      hblank_d = 1'b0;
      line_d   = line_inc;
      if (line_inc == lst_pkg::VisibleLines) begin
        vblank_d                = 1'b1;
        result_o.vblank_irq_req  = cfg_i.vblank_irq_enable;
        result_o.vblank_dma_trig = 1'b1;
        result_o.frame_swap      = 1'b1;
      end else if (line_inc == lst_pkg::VblankEndLine) begin
        vblank_d = 1'b0;
      end else if (line_inc == lst_pkg::TotalLines) begin
        line_d = '0;
      end
      match_d                = (line_d == cfg_i.line_compare);
      result_o.match_irq_req = match_d && cfg_i.line_match_irq_enable;
    end else if (hflag_hit) begin
      hblank_d = 1'b1;
    end

    // The cycle counter saturates at its full scale.
    count_d = next_sum[lst_pkg::SumW-1] ? lst_pkg::CountMax[lst_pkg::CountW-1:0]
                                        : next_sum[lst_pkg::CountW-1:0];

    result_o.line_number = line_d;
    result_o.in_hblank   = hblank_d;
    result_o.in_vblank   = vblank_d;
    result_o.line_match  = match_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      line_q   <= '0;
      hblank_q <= 1'b0;
      vblank_q <= 1'b0;
      match_q  <= 1'b0;
    end else if (step_i) begin
      count_q  <= count_d;
      line_q   <= line_d;
      hblank_q <= hblank_d;
      vblank_q <= vblank_d;
      match_q  <= match_d;
    end
  end

endmodule
